FILE: hw/rtl/rkx_pkg.sv
// ----------------------------------------------------------------------------
// rkx_pkg
// Shared types and constants for the rolling key XOR stream cipher.
// ----------------------------------------------------------------------------
package rkx_pkg;

  // Input item kinds
  localparam logic KIND_KEY  = 1'b0;
  localparam logic KIND_DATA = 1'b1;

  // Key length register lower limit and reset value
  localparam logic [7:0] KEY_LEN_MIN   = 8'd2;
  localparam logic [7:0] KEY_LEN_RESET = 8'd2;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SUM,
    ST_DIV,
    ST_UPD,
    ST_WRAP,
    ST_DONE
  } rkx_state_e;

endpackage

FILE: hw/rtl/rkx_ram.sv
// ----------------------------------------------------------------------------
// rkx_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module rkx_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hw/rtl/rkx_avg_div.sv
// ----------------------------------------------------------------------------
// rkx_avg_div
// Iterative restoring divider: signed key sum over key length, truncated
// toward zero, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rkx_avg_div #(
  parameter int SW = 15
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic signed [SW-1:0] sum_i,
  input  logic [7:0]           len_i,
  output logic                 done_o,
  output logic [7:0]           avg_o
);

  localparam int CNTW = $clog2(SW);

  logic            busy_q;
  logic            done_q;
  logic [CNTW-1:0] cnt_q;
  logic            neg_q;
  logic [SW-1:0]   dvd_q;
  logic [SW-1:0]   quo_q;
  logic [7:0]      rem_q;
  logic [SW-1:0]   mag;
  logic [8:0]      rem_sh;
  logic            ge;
  logic [8:0]      rem_sub;
  logic [7:0]      quo_lo;

  // Magnitude of the dividend
  assign mag = sum_i[SW-1] ? (~sum_i + SW'(1)) : sum_i;

  // One restoring step
  assign rem_sh  = {rem_q, dvd_q[SW-1]};
  assign ge      = (rem_sh >= {1'b0, len_i});
  assign rem_sub = rem_sh - {1'b0, len_i};

  // Control: count steps, pulse done after the last one
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + CNTW'(1);
      if (cnt_q == CNTW'(SW - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  // Datapath: shift dividend, build quotient
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q <= sum_i[SW-1];
      dvd_q <= mag;
      quo_q <= '0;
      rem_q <= '0;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[SW-2:0], 1'b0};
      quo_q <= {quo_q[SW-2:0], ge};
      rem_q <= ge ? rem_sub[7:0] : rem_sh[7:0];
    end
  end

  // Restore the sign; the quotient magnitude never exceeds 128
  assign quo_lo = quo_q[7:0];
  assign avg_o  = neg_q ? (~quo_lo + 8'd1) : quo_lo;
  assign done_o = done_q;

endmodule

FILE: hw/rtl/rolling_key_xor_stream_cipher.sv
// ----------------------------------------------------------------------------
// rolling_key_xor_stream_cipher
// Self-inverse XOR stream cipher with a key rewritten at every data byte.
// ----------------------------------------------------------------------------
// Key load: no result. Data byte: each key entry is read and rewritten, the
//   first entry wrapped to the last position, then the result registered; the
//   first data byte after a restart adds an averaging pass over the key and a
//   divider run before the update. No new input is taken until then.
// The key RAM takes one read and one write per key entry in the update pass.
// Reset clears control, key length to 2 and the average; the key RAM is not
//   cleared and entries are undefined until loaded.
module rolling_key_xor_stream_cipher
  import rkx_pkg::*;
#(
  parameter int MAX_KEY     = 128,
  parameter int CHUNK_BYTES = 100000
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  // input channel
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic       kind_i,
  input  logic [6:0] key_index_i,
  input  logic [7:0] value_i,
  // output channel
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_byte_o,
  // configuration channel
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [7:0] cfg_data_i
);

  localparam int AW  = $clog2(MAX_KEY);
  localparam int CW  = AW + 1;
  localparam int SW  = AW + 8;
  localparam int CHW = $clog2(CHUNK_BYTES + 1);

  rkx_state_e state_q, state_d;

  logic [7:0]     len_q;
  logic [8:0]     len_ext;
  logic [8:0]     len_m1;
  logic           avg_rdy_q;
  logic [7:0]     avg_q;
  logic [CHW-1:0] chunk_q;
  logic [CHW:0]   chunk_inc;
  logic [AW-1:0]  sel_q;
  logic [CW-1:0]  rd_cnt_q;
  logic           rvld_q;
  logic [CW-1:0]  ridx_q;
  logic [CW-1:0]  wr_idx;
  logic [7:0]     first_q;
  logic [7:0]     prev_q;
  logic [7:0]     res_q;
  logic [7:0]     data_q;
  logic signed [SW-1:0] sum_q;
  logic signed [SW-1:0] sum_d;
  logic [7:0]     out_byte_q;
  logic           out_valid_q;

  logic           in_acc;
  logic           key_ld;
  logic           data_acc;
  logic           cfg_wr;
  logic           cfg_ok;
  logic           restart;
  logic           issue_rd;
  logic           rd_last;
  logic           out_free;
  logic           div_start;
  logic           div_done;
  logic [7:0]     div_avg;
  logic [7:0]     new_val;

  logic           ram_we;
  logic [AW-1:0]  ram_waddr;
  logic [7:0]     ram_wdata;
  logic [7:0]     ram_rdata;

  // Handshake decode
  assign in_acc   = in_valid_i && !in_stall_o;
  assign key_ld   = in_acc && (kind_i == KIND_KEY);
  assign data_acc = in_acc && (kind_i == KIND_DATA);
  assign cfg_wr   = cfg_valid_i && cfg_ready_o;
  assign cfg_ok   = (cfg_data_i >= KEY_LEN_MIN) && (9'(cfg_data_i) <= 9'(MAX_KEY));
  assign restart  = key_ld || (cfg_wr && cfg_ok);
  assign out_free = !out_valid_q || !out_stall_i;

  // Key walk helpers
  assign len_ext = {1'b0, len_q};
  assign len_m1  = len_ext - 9'd1;
  assign rd_last = rvld_q && (9'(ridx_q) == len_m1);
  assign wr_idx  = ridx_q - CW'(1);
  assign new_val = avg_q + prev_q - ram_rdata;
  assign sum_d   = sum_q + {{(SW-8){ram_rdata[7]}}, ram_rdata};

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (data_acc) begin
          state_d = avg_rdy_q ? ST_UPD : ST_SUM;
        end
      end
      ST_SUM: begin
        if (rd_last) begin
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_d = ST_UPD;
        end
      end
      ST_UPD: begin
        if (rd_last) begin
          state_d = ST_WRAP;
        end
      end
      ST_WRAP: begin
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control outputs
  always_comb begin
    in_stall_o  = 1'b1;
    cfg_ready_o = 1'b0;
    issue_rd    = 1'b0;
    div_start   = 1'b0;
    ram_we      = 1'b0;
    ram_waddr   = wr_idx[AW-1:0];
    ram_wdata   = new_val;
    case (state_q)
      ST_IDLE: begin
        // Hold input while a key length write is offered
        in_stall_o  = cfg_valid_i;
        cfg_ready_o = 1'b1;
        ram_we      = key_ld && (9'(key_index_i) < 9'(MAX_KEY));
        ram_waddr   = AW'(key_index_i);
        ram_wdata   = value_i;
      end
      ST_SUM: begin
        issue_rd  = 9'(rd_cnt_q) < len_ext;
        div_start = rd_last;
      end
      ST_UPD: begin
        issue_rd = 9'(rd_cnt_q) < len_ext;
        ram_we   = rvld_q && (ridx_q != '0);
      end
      ST_WRAP: begin
        ram_we    = 1'b1;
        ram_waddr = len_m1[AW-1:0];
        ram_wdata = first_q;
      end
      default: begin
        in_stall_o = 1'b1;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      len_q       <= KEY_LEN_RESET;
      avg_rdy_q   <= 1'b0;
      avg_q       <= '0;
      chunk_q     <= '0;
      sel_q       <= '0;
      rd_cnt_q    <= '0;
      rvld_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;

      // Key length write
      if (cfg_wr && cfg_ok) begin
        len_q <= cfg_data_i;
      end

      // Restart the stream, or take the fresh average
      if (restart) begin
        avg_rdy_q <= 1'b0;
        chunk_q   <= '0;
        sel_q     <= '0;
      end else if (div_done) begin
        avg_rdy_q <= 1'b1;
        avg_q     <= div_avg;
      end

      // Read address walk
      rvld_q <= issue_rd;
      if (issue_rd) begin
        rd_cnt_q <= rd_cnt_q + CW'(1);
      end else if (state_q != ST_SUM && state_q != ST_UPD) begin
        rd_cnt_q <= '0;
      end

      // Present the result and advance the positions
      if (state_q == ST_DONE && out_free) begin
        out_valid_q <= 1'b1;
        if (chunk_inc == (CHW+1)'(CHUNK_BYTES)) begin
          chunk_q <= '0;
          sel_q   <= '0;
        end else begin
          chunk_q <= chunk_inc[CHW-1:0];
          sel_q   <= (9'(sel_q) + 9'd1 == len_m1) ? '0 : sel_q + AW'(1);
        end
      end else if (out_valid_q && !out_stall_i) begin
        // Drop a taken result
        out_valid_q <= 1'b0;
      end
    end
  end

  assign chunk_inc = {1'b0, chunk_q} + (CHW+1)'(1);

  // Payload registers
  always_ff @(posedge clk_i) begin
    ridx_q <= rd_cnt_q;
    if (data_acc) begin
      data_q <= value_i;
    end
    // Accumulate the signed key sum
    if (state_q == ST_IDLE) begin
      sum_q <= '0;
    end else if (state_q == ST_SUM && rvld_q) begin
      sum_q <= sum_d;
    end
    // Chain the key update; capture the selected entry
    if (state_q == ST_UPD && rvld_q) begin
      if (ridx_q == '0) begin
        first_q <= ram_rdata;
        prev_q  <= ram_rdata;
      end else begin
        prev_q <= new_val;
        if (wr_idx[AW-1:0] == sel_q) begin
          res_q <= new_val;
        end
      end
    end
    if (state_q == ST_DONE && out_free) begin
      out_byte_q <= res_q ^ data_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;

  // Key store
  rkx_ram #(
    .WIDTH (8),
    .DEPTH (MAX_KEY)
  ) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (rd_cnt_q[AW-1:0]),
    .rdata_o (ram_rdata)
  );

  // Average divider
  rkx_avg_div #(
    .SW (SW)
  ) u_avg_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .sum_i   (sum_d),
    .len_i   (len_q),
    .done_o  (div_done),
    .avg_o   (div_avg)
  );

endmodule

FILE: hw/rtl/rkx_checker.sv
// ----------------------------------------------------------------------------
// rkx_checker
// Port-level checks for the rolling key XOR stream cipher.
// ----------------------------------------------------------------------------
module rkx_checker
  import rkx_pkg::*;
(
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic       kind_i,
  input logic [6:0] key_index_i,
  input logic [7:0] value_i,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [7:0] out_byte_o,
  input logic       cfg_valid_i,
  input logic       cfg_ready_o,
  input logic [7:0] cfg_data_i
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_byte_o))
    else $error("stalled result changed or dropped");

  // A key load transfer produces no result
  a_key_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && (kind_i == KIND_KEY) && !out_valid_o |=> !out_valid_o)
    else $error("result after key load");

  // A data transfer occupies the block
  a_data_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && (kind_i == KIND_DATA) |=> in_stall_o && !cfg_ready_o)
    else $error("block free right after data transfer");

  // A new result only follows work in progress
  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result without a data byte in progress");

endmodule

bind rolling_key_xor_stream_cipher rkx_checker u_rkx_checker (.*);
